FILE: design/rgbhsv_pkg.sv
// Types and constants for the RGB to HSV converter.
package rgbhsv_pkg;

  localparam int unsigned ChanBits  = 8;
  localparam int unsigned HueBits   = 15;
  localparam int unsigned HueQBits  = 12;  // hue quotient <= 3840
  localparam int unsigned SatQBits  = 8;   // saturation quotient <= 255
  localparam int unsigned DivStages = HueQBits;

  localparam logic [HueBits-1:0] HueOffRed   = 15'd0;
  localparam logic [HueBits-1:0] HueOffGreen = 15'd7680;
  localparam logic [HueBits-1:0] HueOffBlue  = 15'd15360;
  localparam logic [HueBits:0]   HueCircle   = 16'd23040;

  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sector_e;

  // One stage of the divider pipeline: two restoring dividers side by side.
  typedef struct packed {
    logic [ChanBits-1:0] mx;
    logic [ChanBits-1:0] delta;
    sector_e             sector;
    logic                neg;
    logic [ChanBits-1:0] hrem;
    logic [HueQBits-1:0] hbits;
    logic [HueQBits-1:0] hq;
    logic [ChanBits-1:0] srem;
    logic [SatQBits-1:0] sbits;
    logic [SatQBits-1:0] sq;
  } div_stage_t;

endpackage

FILE: design/rgb_to_hsv_converter.sv
// RGB to HSV converter: fully pipelined, one pixel per clock.
//
// A pixel request is taken on every clock edge with start_i high (busy_o
// is always low). Its result appears on hue_o, saturation_o and
// brightness_o for one cycle with done_o high: the request edge loads the
// stage that holds max, delta and the hue sector, twelve stages of one-bit
// restoring division produce the hue and saturation quotients in parallel,
// and one stage forms the final hue. Results come out in request order and
// cannot be held off. Hue is in 1/64 degree (0..23039), saturation is
// floor(delta*255/max), brightness is max.
module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [ChanBits-1:0] red_i,
  input  logic [ChanBits-1:0] green_i,
  input  logic [ChanBits-1:0] blue_i,
  output logic                done_o,
  output logic [HueBits-1:0]  hue_o,
  output logic [ChanBits-1:0] saturation_o,
  output logic [ChanBits-1:0] brightness_o
);

  logic [DivStages:0] vld_q;
  div_stage_t         div_q [DivStages+1];
  div_stage_t         s1_d;

  logic                done_q;
  logic [HueBits-1:0]  hue_q, hue_d;
  logic [ChanBits-1:0] sat_q, sat_d;
  logic [ChanBits-1:0] bright_q;

  // Front stage: extremes, sector, |diff| and dividends
  logic [ChanBits-1:0] mx, mn, delta, ndiff;
  logic [ChanBits:0]   diff;
  sector_e             sector;
  logic [HueQBits-1:0] diff15;
  logic [15:0]         sat_num;

  assign busy_o = 1'b0;  // pipeline takes a request every cycle

  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      sector = SecRed;
      mx     = red_i;
      diff   = {1'b0, green_i} - {1'b0, blue_i};
    end else if (green_i >= blue_i) begin
      sector = SecGreen;
      mx     = green_i;
      diff   = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      sector = SecBlue;
      mx     = blue_i;
      diff   = {1'b0, red_i} - {1'b0, green_i};
    end
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    delta  = mx - mn;
    ndiff  = diff[ChanBits] ? ChanBits'(-diff) : diff[ChanBits-1:0];
    // |diff| * 3840 = (|diff| * 15) << 8; the low byte is zero
    diff15  = {ndiff, 4'b0} - {4'b0, ndiff};
    sat_num = {delta, 8'b0} - {8'b0, delta};

    s1_d        = '0;
    s1_d.mx     = mx;
    s1_d.delta  = delta;
    s1_d.sector = sector;
    s1_d.neg    = diff[ChanBits];
    // quotients fit 12 and 8 bits, so the top of each dividend is below delta/max
    s1_d.hrem   = diff15[HueQBits-1:HueQBits-ChanBits];
    s1_d.hbits  = {diff15[HueQBits-ChanBits-1:0], 8'b0};
    s1_d.srem   = sat_num[15:8];
    s1_d.sbits  = sat_num[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[DivStages-1:0], start_i & ~busy_o};
      done_q <= vld_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    div_q[0] <= s1_d;
  end

  // Divider stages: one hue quotient bit per stage, one saturation bit in the first eight
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    logic [ChanBits:0] h_trial;
    logic [ChanBits:0] s_trial;
    div_stage_t        stage_d;

    always_comb begin
      stage_d       = div_q[s];
      h_trial       = {div_q[s].hrem, div_q[s].hbits[HueQBits-1]};
      stage_d.hbits = {div_q[s].hbits[HueQBits-2:0], 1'b0};
      if (h_trial >= {1'b0, div_q[s].delta}) begin
        stage_d.hrem = ChanBits'(h_trial - {1'b0, div_q[s].delta});
        stage_d.hq   = {div_q[s].hq[HueQBits-2:0], 1'b1};
      end else begin
        stage_d.hrem = h_trial[ChanBits-1:0];
        stage_d.hq   = {div_q[s].hq[HueQBits-2:0], 1'b0};
      end
      s_trial = {div_q[s].srem, div_q[s].sbits[SatQBits-1]};
      if (s < SatQBits) begin
        stage_d.sbits = {div_q[s].sbits[SatQBits-2:0], 1'b0};
        if (s_trial >= {1'b0, div_q[s].mx}) begin
          stage_d.srem = ChanBits'(s_trial - {1'b0, div_q[s].mx});
          stage_d.sq   = {div_q[s].sq[SatQBits-2:0], 1'b1};
        end else begin
          stage_d.srem = s_trial[ChanBits-1:0];
          stage_d.sq   = {div_q[s].sq[SatQBits-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[s+1] <= stage_d;
    end
  end

  // Final stage: sector offset, sign and wrap
  logic [HueBits-1:0] hue_off;
  logic [HueBits:0]   hue_raw;
  div_stage_t         fin;

  always_comb begin
    fin = div_q[DivStages];
    case (fin.sector)
      SecRed:   hue_off = HueOffRed;
      SecGreen: hue_off = HueOffGreen;
      SecBlue:  hue_off = HueOffBlue;
      default:  hue_off = HueOffRed;
    endcase
    if (fin.neg) begin
      hue_raw = {1'b0, hue_off} - {4'b0, fin.hq};
    end else begin
      hue_raw = {1'b0, hue_off} + {4'b0, fin.hq};
    end
    if (hue_raw[HueBits]) begin
      hue_raw = hue_raw + HueCircle;  // only the red sector goes negative
    end
    hue_d = (fin.delta == '0) ? '0 : hue_raw[HueBits-1:0];
    sat_d = (fin.mx == '0) ? '0 : fin.sq;
  end

  always_ff @(posedge clk_i) begin
    hue_q    <= hue_d;
    sat_q    <= sat_d;
    bright_q <= fin.mx;
  end

  assign done_o       = done_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> hue_o < 15'd23040)
    else $error("hue out of range");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && brightness_o == '0 |-> saturation_o == '0 && hue_o == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturation_o == '0 |-> hue_o == '0)
    else $error("grey pixel with nonzero hue");

  // a nonzero hue needs a nonzero delta, which gives at least one step of saturation
  a_hue_needs_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hue_o != '0 |-> saturation_o != '0)
    else $error("colored pixel with zero saturation");

endmodule
